FILE: rtl/core/range_add_max_segment_tree_top_defines.svh
// assertion helpers for the range add / max tree
`ifndef RANGE_ADD_MAX_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_ADD_MAX_SEGMENT_TREE_TOP_DEFINES_SVH

// condition must hold in the same cycle
`define RAMST_IMPLY(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("ramst check failed");

// condition must hold in the next cycle
`define RAMST_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("ramst check failed");

`endif

FILE: rtl/core/ramst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ramst_pkg;
	localparam int DEF_LEAVES = 1024;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 10;
	localparam int DELTA_W    = 24;

	typedef struct packed {
		logic rd;
		logic wr_pend;
		logic wr_nmax;
		logic wr_zero;
		logic cap_a;
		logic latch;
		logic clr_best;
		logic out;
	} cmd_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] x);
		logic signed [DATA_W:0] mx;
		logic signed [DATA_W:0] mn;
		mx = (DATA_W+1)'(2**(DATA_W-1) - 1);
		mn = -mx - (DATA_W+1)'(1);
		if (x > mx) return mx[DATA_W-1:0];
		else if (x < mn) return mn[DATA_W-1:0];
		else return x[DATA_W-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ramst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ramst_ctrl #(
	parameter int LEAVES = 1024,
	parameter int AW = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        action,
	input  wire logic [ramst_pkg::IDX_W-1:0] lo,
	input  wire logic [ramst_pkg::IDX_W-1:0] hi,
	output logic                             busy,
	output ramst_pkg::cmd_t                  cmd,
	output logic [AW-1:0]                    addr
);
	import ramst_pkg::*;

	localparam int LW    = $clog2(LEAVES);
	localparam int CW    = (LW > IDX_W) ? LW : IDX_W;
	localparam int NODES = 4 * LEAVES;
	localparam int SD    = LW + 2;
	localparam int SIW   = $clog2(SD);
	localparam int SPW   = $clog2(SD + 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_TOP  = 3'd2;
	localparam logic [2:0] S_PADD = 3'd3;
	localparam logic [2:0] S_RDB  = 3'd4;
	localparam logic [2:0] S_MAX  = 3'd5;
	localparam logic [2:0] S_ROOT = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	localparam logic [1:0] PH_NEW   = 2'd0;
	localparam logic [1:0] PH_LEFT  = 2'd1;
	localparam logic [1:0] PH_RIGHT = 2'd2;

	logic [2:0]     state_q;
	logic [AW-1:0]  cnt_q;
	logic           res_q;
	logic [CW-1:0]  lo_q, hi_q;
	logic [SPW-1:0] sp_q;
	logic [AW-1:0]  stk_p  [SD];
	logic [CW-1:0]  stk_s  [SD];
	logic [CW-1:0]  stk_t  [SD];
	logic [1:0]     stk_ph [SD];

	logic [SIW-1:0] top_idx, push_idx;
	logic [AW-1:0]  tp, left_p, right_p;
	logic [CW-1:0]  ts, tt, mid, hi_c, lo_e, hi_e, last_leaf;
	logic [1:0]     tph;
	logic           covered;

	assign top_idx   = SIW'(sp_q - SPW'(1));
	assign push_idx  = sp_q[SIW-1:0];
	assign tp        = stk_p[top_idx];
	assign ts        = stk_s[top_idx];
	assign tt        = stk_t[top_idx];
	assign tph       = stk_ph[top_idx];
	assign mid       = ts + ((tt - ts) >> 1);
	assign covered   = (lo_q <= ts) && (tt <= hi_q);
	assign left_p    = {tp[AW-2:0], 1'b0};
	assign right_p   = {tp[AW-2:0], 1'b1};
	assign last_leaf = CW'(LEAVES - 1);
	assign lo_e      = CW'(lo);
	assign hi_e      = CW'(hi);
	assign hi_c      = (hi_e > last_leaf) ? last_leaf : hi_e;
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		cmd  = '0;
		addr = '0;
		case (state_q)
			S_CLR: begin
				cmd.wr_zero  = 1'b1;
				cmd.clr_best = res_q;
				addr         = cnt_q;
			end
			S_IDLE: cmd.latch = start;
			S_TOP: begin
				if (tph == PH_NEW) begin
					cmd.rd = covered;
					addr   = tp;
				end else if (tph != PH_LEFT) begin
					cmd.rd = 1'b1;
					addr   = left_p;
				end
			end
			S_PADD: begin
				cmd.wr_pend = 1'b1;
				addr        = tp;
			end
			S_RDB: begin
				cmd.rd    = 1'b1;
				cmd.cap_a = 1'b1;
				addr      = right_p;
			end
			S_MAX: begin
				cmd.wr_nmax = 1'b1;
				addr        = tp;
			end
			S_ROOT: begin
				cmd.rd = 1'b1;
				addr   = AW'(1);
			end
			S_OUT: cmd.out = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			res_q   <= 1'b0;
			sp_q    <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(NODES - 1)) state_q <= res_q ? S_ROOT : S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						if (action) begin
							state_q <= S_CLR;
							cnt_q   <= '0;
							res_q   <= 1'b1;
						end else if (lo_e <= hi_c) begin
							sp_q    <= SPW'(1);
							state_q <= S_TOP;
						end else begin
							state_q <= S_ROOT;
						end
					end
				end
				S_TOP: begin
					if (tph == PH_NEW) begin
						if (covered) state_q <= S_PADD;
						else if (lo_q <= mid) sp_q <= sp_q + SPW'(1);
					end else if (tph == PH_LEFT) begin
						if (hi_q > mid) sp_q <= sp_q + SPW'(1);
					end else begin
						state_q <= S_RDB;
					end
				end
				S_PADD, S_MAX: begin
					sp_q    <= sp_q - SPW'(1);
					state_q <= (sp_q == SPW'(1)) ? S_ROOT : S_TOP;
				end
				S_RDB:  state_q <= S_MAX;
				S_ROOT: state_q <= S_OUT;
				S_OUT: begin
					res_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// traversal stack, no reset needed: sp_q guards every entry
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			lo_q         <= lo_e;
			hi_q         <= hi_c;
			stk_p[0]     <= AW'(1);
			stk_s[0]     <= '0;
			stk_t[0]     <= last_leaf;
			stk_ph[0]    <= PH_NEW;
		end
		if (state_q == S_TOP && !(tph == PH_NEW && covered)) begin
			if (tph == PH_NEW) begin
				stk_ph[top_idx] <= PH_LEFT;
				if (lo_q <= mid) begin
					stk_p[push_idx]  <= left_p;
					stk_s[push_idx]  <= ts;
					stk_t[push_idx]  <= mid;
					stk_ph[push_idx] <= PH_NEW;
				end
			end else if (tph == PH_LEFT) begin
				stk_ph[top_idx] <= PH_RIGHT;
				if (hi_q > mid) begin
					stk_p[push_idx]  <= right_p;
					stk_s[push_idx]  <= mid + CW'(1);
					stk_t[push_idx]  <= tt;
					stk_ph[push_idx] <= PH_NEW;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/ramst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ramst_dp #(
	parameter int LEAVES = 1024,
	parameter int AW = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ramst_pkg::cmd_t                     cmd,
	input  wire logic [AW-1:0]                       addr,
	input  wire logic signed [ramst_pkg::DELTA_W-1:0] delta,
	output logic                                     done,
	output logic signed [ramst_pkg::DATA_W-1:0]      current_max,
	output logic signed [ramst_pkg::DATA_W-1:0]      best_max
);
	import ramst_pkg::*;

	localparam int NODES = 4 * LEAVES;

	logic signed [DATA_W-1:0]  nmax_mem [NODES];
	logic signed [DATA_W-1:0]  pend_mem [NODES];
	logic signed [DATA_W-1:0]  nm_rd_q, pd_rd_q, a_q, best_q, cur_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic                      done_q;
	logic signed [DATA_W-1:0]  sumv, padd, mx;

	assign sumv = sat32((DATA_W+1)'(nm_rd_q) + (DATA_W+1)'(pd_rd_q));
	assign padd = sat32((DATA_W+1)'(pd_rd_q) + (DATA_W+1)'(delta_q));
	assign mx   = (a_q > sumv) ? a_q : sumv;

	always_ff @(posedge clk) begin
		if (cmd.wr_zero) begin
			nmax_mem[addr] <= '0;
			pend_mem[addr] <= '0;
		end
		if (cmd.wr_pend) pend_mem[addr] <= padd;
		if (cmd.wr_nmax) nmax_mem[addr] <= mx;
		if (cmd.rd) begin
			nm_rd_q <= nmax_mem[addr];
			pd_rd_q <= pend_mem[addr];
		end
		if (cmd.latch) delta_q <= delta;
		if (cmd.cap_a) a_q <= sumv;
		if (cmd.out) cur_q <= sumv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out;
			if (cmd.clr_best) best_q <= '0;
			else if (cmd.out && sumv > best_q) best_q <= sumv;
		end
	end

	assign done        = done_q;
	assign current_max = cur_q;
	assign best_max    = best_q;
endmodule
`default_nettype wire

FILE: rtl/core/range_add_max_segment_tree_top.sv
// one result per request; done strobes for one cycle, receiver cannot stall
// add: a fully covered node passes S_TOP and S_PADD, a partly covered node S_TOP once per
// phase, then S_RDB and S_MAX; S_ROOT and S_OUT follow, all on the single-port node memories
// clear: sweep of all 4*LEAVES node memory entries, then the result
// next request is taken in the cycle done is high: no new request while one is in flight
// reset: the same sweep of all 4*LEAVES entries with busy high and no result
`timescale 1ns / 1ps
`default_nettype none
`include "range_add_max_segment_tree_top_defines.svh"
module range_add_max_segment_tree_top #(
	parameter int LEAVES = ramst_pkg::DEF_LEAVES
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic                                 action,
	input  wire logic [ramst_pkg::IDX_W-1:0]          lo,
	input  wire logic [ramst_pkg::IDX_W-1:0]          hi,
	input  wire logic signed [ramst_pkg::DELTA_W-1:0] delta,
	output logic                                      done,
	output logic signed [ramst_pkg::DATA_W-1:0]       current_max,
	output logic signed [ramst_pkg::DATA_W-1:0]       best_max
);
	import ramst_pkg::*;

	localparam int AW = $clog2(4 * LEAVES);

	cmd_t          cmd;
	logic [AW-1:0] addr;

	ramst_ctrl #(.LEAVES(LEAVES), .AW(AW)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.lo     (lo),
		.hi     (hi),
		.busy   (busy),
		.cmd    (cmd),
		.addr   (addr)
	);

	ramst_dp #(.LEAVES(LEAVES), .AW(AW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (addr),
		.delta       (delta),
		.done        (done),
		.current_max (current_max),
		.best_max    (best_max)
	);

	`RAMST_NEXT(a_start_busy, start && !busy, busy)
	`RAMST_IMPLY(a_done_after_busy, done, $past(busy) && !busy)
	`RAMST_IMPLY(a_best_covers_cur, done, best_max >= current_max)
	`RAMST_IMPLY(a_one_write, 1'b1, $onehot0({cmd.wr_pend, cmd.wr_nmax, cmd.wr_zero}))
endmodule
`default_nettype wire

FILE: tb/tb_range_add_max_segment_tree_top.sv
`timescale 1ns / 1ps
module tb_range_add_max_segment_tree_top;
	import ramst_pkg::*;

	localparam int LEAVES = DEF_LEAVES;
	localparam int NODES  = 4 * LEAVES;
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;
	localparam int DMAX = 8388607;
	localparam int DMIN = -8388608;

	typedef struct {
		int cur;
		int best;
	} max_pair_t;

	typedef struct {
		logic act;
		int   lo;
		int   hi;
		int   delta;
		bit   typed;
		int   cur;
		int   best;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [IDX_W-1:0] lo;
	logic [IDX_W-1:0] hi;
	logic signed [DELTA_W-1:0] delta;
	logic done;
	logic signed [DATA_W-1:0] current_max;
	logic signed [DATA_W-1:0] best_max;

	int tree_max[NODES];
	int tree_pend[NODES];
	int best_seen;
	max_pair_t max_queue[$];
	int errors;
	int idle_pct;

	range_add_max_segment_tree_top #(.LEAVES(LEAVES)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.lo(lo), .hi(hi), .delta(delta), .done(done),
		.current_max(current_max), .best_max(best_max)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int sat(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	function automatic int node_val(int p);
		if (p >= NODES) return 0;
		return sat(longint'(tree_max[p]) + longint'(tree_pend[p]));
	endfunction

	function automatic void tree_add(int p, int s, int t, int l, int h, longint d);
		int mid;
		int a;
		int b;
		if (p >= NODES) return;
		if (l <= s && t <= h) begin
			tree_pend[p] = sat(longint'(tree_pend[p]) + d);
			return;
		end
		mid = s + ((t - s) >> 1);
		if (l <= mid) tree_add(2 * p, s, mid, l, h, d);
		if (h > mid) tree_add(2 * p + 1, mid + 1, t, l, h, d);
		a = node_val(2 * p);
		b = node_val(2 * p + 1);
		tree_max[p] = a > b ? a : b;
	endfunction

	function automatic void tree_clear();
		for (int i = 0; i < NODES; i++) begin
			tree_max[i] = 0;
			tree_pend[i] = 0;
		end
		best_seen = 0;
	endfunction

	function automatic max_pair_t predict_max(logic act, int l, int h, int d);
		max_pair_t r;
		if (act == ACT_CLEAR) begin
			tree_clear();
		end else begin
			if (h > LEAVES - 1) h = LEAVES - 1;
			if (l <= h) tree_add(1, 0, LEAVES - 1, l, h, longint'(d));
		end
		r.cur = node_val(1);
		if (r.cur > best_seen) best_seen = r.cur;
		r.best = best_seen;
		return r;
	endfunction

	task automatic send(logic act, int l, int h, int d, bit typed = 0, int ec = 0, int eb = 0);
		max_pair_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		lo <= l[IDX_W-1:0];
		hi <= h[IDX_W-1:0];
		delta <= d[DELTA_W-1:0];
		do @(posedge clk); while (!(start && !busy));
		r = predict_max(act, l, h, d);
		if (typed) begin
			r.cur = ec;
			r.best = eb;
		end
		max_queue.push_back(r);
	endtask

	function automatic int rand_delta();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom_range(2000) - 1000;
			5, 6, 7: return int'(signed'($urandom_range(24'hffffff) << 8)) >>> 8;
			8: return DMAX;
			default: return DMIN;
		endcase
	endfunction

	task automatic send_random();
		int l;
		int h;
		int t;
		if ($urandom_range(99) < 4) begin
			send(ACT_CLEAR, $urandom_range(1023), $urandom_range(1023),
				int'($urandom_range(24'hffffff)));
		end else begin
			l = $urandom_range(1023);
			h = $urandom_range(1023);
			// mostly proper ranges, some empty ones
			if ($urandom_range(99) < 85 && l > h) begin
				t = l;
				l = h;
				h = t;
			end
			send(ACT_ADD, l, h, rand_delta());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (max_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result cur=%0d best=%0d", current_max, best_max);
			end else begin
				max_pair_t e;
				e = max_queue.pop_front();
				if (current_max !== e.cur || best_max !== e.best) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: cur exp %0d got %0d, best exp %0d got %0d",
							e.cur, current_max, e.best, best_max);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		int wait_cnt;
		errors = 0;
		idle_pct = 0;
		tree_clear();
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_ADD;
		lo <= '0;
		hi <= '0;
		delta <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		rows = '{
			'{ACT_ADD, 0, 1023, DMAX, 1, DMAX, DMAX},
			'{ACT_CLEAR, 5, 9, 123, 1, 0, 0},
			'{ACT_ADD, 0, 1023, DMIN, 1, DMIN, 0},
			'{ACT_ADD, 700, 3, DMAX, 1, DMIN, 0},
			'{ACT_ADD, 0, 0, DMAX, 0, 0, 0},
			'{ACT_ADD, 1023, 1023, DMAX, 0, 0, 0},
			'{ACT_ADD, 1023, 1023, DMAX, 0, 0, 0},
			'{ACT_ADD, 512, 511, -1, 0, 0, 0},
			'{ACT_ADD, 511, 512, -1, 0, 0, 0},
			'{ACT_ADD, 1, 1022, 1, 0, 0, 0},
			'{ACT_ADD, 0, 1023, 0, 0, 0, 0},
			'{ACT_ADD, 1023, 0, DMIN, 0, 0, 0},
			'{ACT_ADD, 341, 682, -5, 0, 0, 0},
			'{ACT_ADD, 0, 511, DMAX, 0, 0, 0},
			'{ACT_CLEAR, 1023, 1023, DMIN, 1, 0, 0},
			'{ACT_ADD, 100, 100, -1, 1, 0, 0},
			'{ACT_ADD, 0, 1023, 1, 0, 0, 0}
		};
		foreach (rows[i])
			send(rows[i].act, rows[i].lo, rows[i].hi, rows[i].delta,
				rows[i].typed, rows[i].cur, rows[i].best);

		// positive saturation on the whole range, then large negative adds on a partial range
		for (int i = 0; i < 260; i++) send(ACT_ADD, 0, 1023, DMAX);
		for (int i = 0; i < 10; i++) send_random();
		for (int i = 0; i < 20; i++) send(ACT_ADD, 3, 1000, DMIN);
		for (int i = 0; i < 10; i++) send_random();
		send(ACT_CLEAR, 0, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 87;
				2: idle_pct = 0;
				default: idle_pct = 30;
			endcase
			for (int i = 0; i < 25; i++) send_random();
		end
		start <= 1'b0;

		wait_cnt = 0;
		while (max_queue.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && max_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
